FILE: src/bcx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcx_pkg
// Shared types, opcode codes and flag helpers for the byte CPU execute unit.
// ----------------------------------------------------------------------------
package bcx_pkg;

  // Status flag bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // Reset values and masks
  localparam logic [7:0] A_RESET  = 8'h00;
  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET  = 8'h04;
  localparam logic [7:0] PLP_MASK = 8'hCF;
  localparam logic [7:0] PHP_SET  = 8'h30;

  // Single-byte opcodes decoded by value
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PLP = 8'h28;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;
  localparam logic [7:0] OP_DEY = 8'h88;
  localparam logic [7:0] OP_INY = 8'hC8;
  localparam logic [7:0] OP_DEX = 8'hCA;
  localparam logic [7:0] OP_INX = 8'hE8;
  localparam logic [7:0] OP_TYA = 8'h98;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_NOP = 8'hEA;
  localparam logic [7:0] OP_BPL = 8'h10;
  localparam logic [7:0] OP_BMI = 8'h30;
  localparam logic [7:0] OP_BVC = 8'h50;
  localparam logic [7:0] OP_BVS = 8'h70;
  localparam logic [7:0] OP_BCC = 8'h90;
  localparam logic [7:0] OP_BCS = 8'hB0;
  localparam logic [7:0] OP_BNE = 8'hD0;
  localparam logic [7:0] OP_BEQ = 8'hF0;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_BIT_ABS = 8'h2C;
  localparam logic [7:0] OP_STA_IMM = 8'h89;

  // Opcode group (low two bits)
  localparam logic [1:0] CC_CTL = 2'd0;
  localparam logic [1:0] CC_ALU = 2'd1;
  localparam logic [1:0] CC_RMW = 2'd2;

  // Operation field (top three bits)
  localparam logic [2:0] AAA_0 = 3'd0;  // ORA / ASL
  localparam logic [2:0] AAA_1 = 3'd1;  // AND / ROL
  localparam logic [2:0] AAA_2 = 3'd2;  // EOR / LSR
  localparam logic [2:0] AAA_3 = 3'd3;  // ADC / ROR
  localparam logic [2:0] AAA_4 = 3'd4;  // STA / STY / STX
  localparam logic [2:0] AAA_5 = 3'd5;  // LDA / LDY / LDX
  localparam logic [2:0] AAA_6 = 3'd6;  // CMP / CPY / DEC
  localparam logic [2:0] AAA_7 = 3'd7;  // SBC / CPX / INC

  // Address mode field value that selects the accumulator for shifts
  localparam logic [2:0] BBB_ACC = 3'd2;

  // Branch flag select (opcode bits 7:6)
  localparam logic [1:0] BR_SEL_N = 2'd0;
  localparam logic [1:0] BR_SEL_V = 2'd1;
  localparam logic [1:0] BR_SEL_C = 2'd2;
  localparam logic [1:0] BR_SEL_Z = 2'd3;

  typedef enum logic [1:0] {
    STACK_NONE = 2'd0,
    STACK_PUSH = 2'd1,
    STACK_PULL = 2'd2
  } stack_op_e;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_data;
    stack_op_e  stack_op;
    logic [7:0] stack_index;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] flags_out;
    logic       illegal;
  } res_t;

  // Update Z and N in a status byte from a result value
  function automatic logic [7:0] set_zn(logic [7:0] p, logic [7:0] v);
    logic [7:0] r;
    r         = p;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

endpackage

FILE: src/bcx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcx_in_if
// Instruction request channel: opcode and operand byte with valid/ready.
// ----------------------------------------------------------------------------
interface bcx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand_byte;

  modport source (output valid, output opcode, output operand_byte, input ready);
  modport sink   (input valid, input opcode, input operand_byte, output ready);
endinterface

FILE: src/bcx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcx_out_if
// Result channel: store, stack, branch and register state with valid/ready.
// ----------------------------------------------------------------------------
interface bcx_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] write_data;
  logic [1:0] stack_op;
  logic [7:0] stack_index;
  logic       branch_taken;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] flags_out;
  logic       illegal;

  modport source (
    output valid, output write_valid, output write_data, output stack_op,
    output stack_index, output branch_taken, output acc_out, output x_out,
    output y_out, output flags_out, output illegal, input ready
  );
  modport sink (
    input valid, input write_valid, input write_data, input stack_op,
    input stack_index, input branch_taken, input acc_out, input x_out,
    input y_out, input flags_out, input illegal, output ready
  );
endinterface

FILE: src/byte_cpu_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_cpu_execute_unit_top
// Execute stage of an 8-bit accumulator CPU: one instruction per request.
//
// Usage:
//   in_i  carries one request per instruction: the opcode and its operand
//         byte (immediate, loaded or pulled stack byte).
//   out_o returns exactly one result per request: store data, stack access,
//         branch decision, the registers A X Y and P after the instruction,
//         and an illegal flag for opcodes not executed here.
//   A request accepted sits in the request register, is executed from
//   there, and its result is captured in the result register and shown
//   valid from there.
//   Throughput is one instruction per cycle while the receiver keeps taking
//   results; the architectural registers update in the same cycle the
//   result is captured, so the next request sees them with no bubble.
//   Reset clears A, X, Y to zero, sets S to 0xFD and P to 0x04 (I set), and
//   empties both pipeline registers.
//   When the receiver stalls, the result register holds, the request
//   register fills, and then in_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module byte_cpu_execute_unit_top
  import bcx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bcx_in_if.sink    in_i,
  bcx_out_if.source out_o
);

  // Request register
  logic       req_valid_q;
  logic [7:0] op_q;
  logic [7:0] m_q;

  // Result register
  logic       res_valid_q;
  res_t       res_q;
  res_t       res_d;

  // Architectural registers
  logic [7:0] a_q, a_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] s_q, s_d;
  logic [7:0] p_q, p_d;

  logic advance;
  logic req_ready;

  // Advance when the result slot is free or being drained this cycle
  assign advance   = !res_valid_q || out_o.ready;
  assign req_ready = !req_valid_q || advance;
  assign in_i.ready = req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (req_ready && in_i.valid) begin
      op_q <= in_i.opcode;
      m_q  <= in_i.operand_byte;
    end
  end

  // Execute: all decode and datapath for one instruction
  always_comb begin
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    logic       carry;
    logic [8:0] sum9;
    logic [7:0] v;
    logic [7:0] r;
    logic       nc;
    logic       flag_sel;

    aaa   = op_q[7:5];
    bbb   = op_q[4:2];
    cc    = op_q[1:0];
    carry = p_q[FLAG_C];
    sum9  = '0;
    v     = '0;
    r     = '0;
    nc    = 1'b0;
    flag_sel = 1'b0;

    a_d = a_q;
    x_d = x_q;
    y_d = y_q;
    s_d = s_q;
    p_d = p_q;

    res_d              = '0;
    res_d.stack_op     = STACK_NONE;

    case (op_q)
      OP_PHP: begin
        res_d.write_valid = 1'b1;
        res_d.write_data  = p_q | PHP_SET;
        res_d.stack_op    = STACK_PUSH;
        res_d.stack_index = s_q;
        s_d = s_q - 8'd1;
      end
      OP_PHA: begin
        res_d.write_valid = 1'b1;
        res_d.write_data  = a_q;
        res_d.stack_op    = STACK_PUSH;
        res_d.stack_index = s_q;
        s_d = s_q - 8'd1;
      end
      OP_PLP: begin
        s_d = s_q + 8'd1;
        res_d.stack_op    = STACK_PULL;
        res_d.stack_index = s_d;
        p_d = m_q & PLP_MASK;
      end
      OP_PLA: begin
        s_d = s_q + 8'd1;
        res_d.stack_op    = STACK_PULL;
        res_d.stack_index = s_d;
        a_d = m_q;
        p_d = set_zn(p_q, m_q);
      end
      OP_CLC: p_d[FLAG_C] = 1'b0;
      OP_SEC: p_d[FLAG_C] = 1'b1;
      OP_CLI: p_d[FLAG_I] = 1'b0;
      OP_SEI: p_d[FLAG_I] = 1'b1;
      OP_CLV: p_d[FLAG_V] = 1'b0;
      OP_CLD: p_d[FLAG_D] = 1'b0;
      OP_SED: p_d[FLAG_D] = 1'b1;
      OP_DEY: begin
        y_d = y_q - 8'd1;
        p_d = set_zn(p_q, y_d);
      end
      OP_INY: begin
        y_d = y_q + 8'd1;
        p_d = set_zn(p_q, y_d);
      end
      OP_DEX: begin
        x_d = x_q - 8'd1;
        p_d = set_zn(p_q, x_d);
      end
      OP_INX: begin
        x_d = x_q + 8'd1;
        p_d = set_zn(p_q, x_d);
      end
      OP_TYA: begin
        a_d = y_q;
        p_d = set_zn(p_q, y_q);
      end
      OP_TAY: begin
        y_d = a_q;
        p_d = set_zn(p_q, a_q);
      end
      OP_TXA: begin
        a_d = x_q;
        p_d = set_zn(p_q, x_q);
      end
      OP_TAX: begin
        x_d = a_q;
        p_d = set_zn(p_q, a_q);
      end
      OP_TXS: s_d = x_q;
      OP_TSX: begin
        x_d = s_q;
        p_d = set_zn(p_q, s_q);
      end
      OP_NOP: ;
      OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
        case (op_q[7:6])
          BR_SEL_N: flag_sel = p_q[FLAG_N];
          BR_SEL_V: flag_sel = p_q[FLAG_V];
          BR_SEL_C: flag_sel = p_q[FLAG_C];
          BR_SEL_Z: flag_sel = p_q[FLAG_Z];
          default:  flag_sel = 1'b0;
        endcase
        res_d.branch_taken = (flag_sel == op_q[5]);
      end
      default: begin
        case (cc)
          CC_ALU: begin
            if (op_q == OP_STA_IMM) begin
              res_d.illegal = 1'b1;
            end else begin
              case (aaa)
                AAA_0: begin
                  a_d = a_q | m_q;
                  p_d = set_zn(p_q, a_d);
                end
                AAA_1: begin
                  a_d = a_q & m_q;
                  p_d = set_zn(p_q, a_d);
                end
                AAA_2: begin
                  a_d = a_q ^ m_q;
                  p_d = set_zn(p_q, a_d);
                end
                AAA_3: begin
                  sum9 = {1'b0, a_q} + {1'b0, m_q} + {8'd0, carry};
                  a_d  = sum9[7:0];
                  p_d  = set_zn(p_q, a_d);
                  p_d[FLAG_C] = sum9[8];
                  p_d[FLAG_V] = ~(a_q[7] ^ m_q[7]) & (a_q[7] ^ sum9[7]);
                end
                AAA_4: begin
                  res_d.write_valid = 1'b1;
                  res_d.write_data  = a_q;
                end
                AAA_5: begin
                  a_d = m_q;
                  p_d = set_zn(p_q, m_q);
                end
                AAA_6: begin
                  sum9 = {1'b0, a_q} + {1'b0, ~m_q} + 9'd1;
                  p_d  = set_zn(p_q, sum9[7:0]);
                  p_d[FLAG_C] = sum9[8];
                end
                default: begin
                  // SBC: add the inverted operand with carry in
                  sum9 = {1'b0, a_q} + {1'b0, ~m_q} + {8'd0, carry};
                  a_d  = sum9[7:0];
                  p_d  = set_zn(p_q, a_d);
                  p_d[FLAG_C] = sum9[8];
                  p_d[FLAG_V] = (a_q[7] ^ m_q[7]) & (a_q[7] ^ sum9[7]);
                end
              endcase
            end
          end
          CC_CTL: begin
            if (op_q == OP_BIT_ZP || op_q == OP_BIT_ABS) begin
              p_d[FLAG_Z] = ((m_q & a_q) == 8'h00);
              p_d[FLAG_V] = m_q[6];
              p_d[FLAG_N] = m_q[7];
            end else if (aaa == AAA_4 && (bbb inside {3'd1, 3'd3, 3'd5})) begin
              res_d.write_valid = 1'b1;
              res_d.write_data  = y_q;
            end else if (aaa == AAA_5 && (bbb inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7})) begin
              y_d = m_q;
              p_d = set_zn(p_q, m_q);
            end else if (aaa == AAA_6 && (bbb inside {3'd0, 3'd1, 3'd3})) begin
              sum9 = {1'b0, y_q} + {1'b0, ~m_q} + 9'd1;
              p_d  = set_zn(p_q, sum9[7:0]);
              p_d[FLAG_C] = sum9[8];
            end else if (aaa == AAA_7 && (bbb inside {3'd0, 3'd1, 3'd3})) begin
              sum9 = {1'b0, x_q} + {1'b0, ~m_q} + 9'd1;
              p_d  = set_zn(p_q, sum9[7:0]);
              p_d[FLAG_C] = sum9[8];
            end else begin
              res_d.illegal = 1'b1;
            end
          end
          CC_RMW: begin
            if (aaa <= AAA_3 && (bbb == BBB_ACC || bbb[0])) begin
              v = (bbb == BBB_ACC) ? a_q : m_q;
              case (aaa)
                AAA_0: begin
                  nc = v[7];
                  r  = {v[6:0], 1'b0};
                end
                AAA_1: begin
                  nc = v[7];
                  r  = {v[6:0], carry};
                end
                AAA_2: begin
                  nc = v[0];
                  r  = {1'b0, v[7:1]};
                end
                default: begin
                  nc = v[0];
                  r  = {carry, v[7:1]};
                end
              endcase
              p_d = set_zn(p_q, r);
              p_d[FLAG_C] = nc;
              if (bbb == BBB_ACC) begin
                a_d = r;
              end else begin
                res_d.write_valid = 1'b1;
                res_d.write_data  = r;
              end
            end else if (aaa >= AAA_6 && bbb[0]) begin
              r = (aaa == AAA_6) ? (m_q - 8'd1) : (m_q + 8'd1);
              p_d = set_zn(p_q, r);
              res_d.write_valid = 1'b1;
              res_d.write_data  = r;
            end else if (aaa == AAA_4 && (bbb inside {3'd1, 3'd3, 3'd5})) begin
              res_d.write_valid = 1'b1;
              res_d.write_data  = x_q;
            end else if (aaa == AAA_5 && (bbb inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7})) begin
              x_d = m_q;
              p_d = set_zn(p_q, m_q);
            end else begin
              res_d.illegal = 1'b1;
            end
          end
          default: res_d.illegal = 1'b1;
        endcase
      end
    endcase

    // Illegal opcodes leave every register untouched
    if (res_d.illegal) begin
      a_d = a_q;
      x_d = x_q;
      y_d = y_q;
      s_d = s_q;
      p_d = p_q;
    end

    res_d.acc_out   = a_d;
    res_d.x_out     = x_d;
    res_d.y_out     = y_d;
    res_d.flags_out = p_d;
  end

  // Commit state and capture the result together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      a_q <= A_RESET;
      x_q <= A_RESET;
      y_q <= A_RESET;
      s_q <= SP_RESET;
      p_q <= P_RESET;
    end else if (advance) begin
      res_valid_q <= req_valid_q;
      if (req_valid_q) begin
        a_q <= a_d;
        x_q <= x_d;
        y_q <= y_d;
        s_q <= s_d;
        p_q <= p_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.write_valid  = res_q.write_valid;
  assign out_o.write_data   = res_q.write_data;
  assign out_o.stack_op     = res_q.stack_op;
  assign out_o.stack_index  = res_q.stack_index;
  assign out_o.branch_taken = res_q.branch_taken;
  assign out_o.acc_out      = res_q.acc_out;
  assign out_o.x_out        = res_q.x_out;
  assign out_o.y_out        = res_q.y_out;
  assign out_o.flags_out    = res_q.flags_out;
  assign out_o.illegal      = res_q.illegal;

endmodule

FILE: tb/tb_byte_cpu_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_cpu_execute_unit_top
// Self-checking bench for the byte CPU execute unit. It starts with a short
// table of directed instructions: unofficial and out-of-scope opcodes, load
// and carry extremes, a flag push and pull, stack pointer wrap and a sample
// of other instruction kinds. Random instructions follow, under three idle
// mixes, a long output stall and a pause that lets the pipeline empty. An
// in-bench copy of the register file and flags predicts every result, and a
// monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_byte_cpu_execute_unit_top;
  import bcx_pkg::*;

  // Opcodes used by the directed table that the package does not name
  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_JAM     = 8'h02;  // unofficial, halts real parts
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_ROR_ACC = 8'h6A;
  localparam logic [7:0] OP_ROL_ZP  = 8'h26;
  localparam logic [7:0] OP_INC_ZP  = 8'hE6;
  localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
  localparam logic [7:0] OP_CPY_IMM = 8'hC0;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_STX_ABS = 8'h8E;

  // Address mode masks, one bit per bbb value that is a legal mode
  localparam logic [7:0] STORE_MODES = 8'h2A;  // zp, abs, zp indexed
  localparam logic [7:0] LOAD_MODES  = 8'hAB;  // imm, zp, abs, indexed
  localparam logic [7:0] CMP_MODES   = 8'h0B;  // imm, zp, abs
  localparam logic [7:0] RMW_MODES   = 8'hAA;  // zp, abs and their indexed

  localparam int RANDOM_PER_PHASE = 300;
  localparam int STALL_AFTER      = 675;      // requests before the long stall
  localparam int STALL_CYCLES     = 200;
  localparam int DRAIN_CYCLES     = 10;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
    logic       typed;   // want holds a hand-written result
    res_t       want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcx_in_if  in_if ();
  bcx_out_if out_if ();

  byte_cpu_execute_unit_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Predicted architectural state
  logic [7:0] acc_q;
  logic [7:0] x_q;
  logic [7:0] y_q;
  logic [7:0] sp_q;
  logic [7:0] p_q;

  res_t      expected_results[$];
  stim_row_t directed_rows[$];

  int  tx_idle_pct = 10;
  int  rx_idle_pct = 88;
  logic rx_hold = 1'b0;

  int  requests_sent   = 0;
  int  results_checked = 0;
  int  error_count     = 0;
  int  cycle_count     = 0;
  int  illegal_count   = 0;
  int  store_count     = 0;
  int  stack_count     = 0;
  int  taken_count     = 0;
  logic [7:0] opcode_sweep = 8'h00;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void update_zn(input logic [7:0] v);
    p_q[FLAG_Z] = (v == 8'h00);
    p_q[FLAG_N] = v[7];
  endfunction

  function automatic void compare_regs(input logic [7:0] r, input logic [7:0] m);
    p_q[FLAG_C] = (r >= m);
    update_zn(r - m);
  endfunction

  // Execute one instruction on the predicted state and return its result
  function automatic res_t execute_instr(input logic [7:0] op, input logic [7:0] mv);
    res_t       r;
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    logic       c_in;
    logic       c_new;
    logic       flag_set;
    logic [8:0] wide;
    logic [7:0] v;
    logic [7:0] sh;
    r    = '0;
    aaa  = op[7:5];
    bbb  = op[4:2];
    cc   = op[1:0];
    c_in = p_q[FLAG_C];
    case (op)
      OP_PHP: begin
        r.write_valid = 1'b1;
        r.write_data  = p_q | PHP_SET;
        r.stack_op    = STACK_PUSH;
        r.stack_index = sp_q;
        sp_q          = sp_q - 8'd1;
      end
      OP_PHA: begin
        r.write_valid = 1'b1;
        r.write_data  = acc_q;
        r.stack_op    = STACK_PUSH;
        r.stack_index = sp_q;
        sp_q          = sp_q - 8'd1;
      end
      OP_PLP: begin
        sp_q          = sp_q + 8'd1;
        r.stack_op    = STACK_PULL;
        r.stack_index = sp_q;
        p_q           = mv & PLP_MASK;
      end
      OP_PLA: begin
        sp_q          = sp_q + 8'd1;
        r.stack_op    = STACK_PULL;
        r.stack_index = sp_q;
        acc_q         = mv;
        update_zn(acc_q);
      end
      OP_CLC: p_q[FLAG_C] = 1'b0;
      OP_SEC: p_q[FLAG_C] = 1'b1;
      OP_CLI: p_q[FLAG_I] = 1'b0;
      OP_SEI: p_q[FLAG_I] = 1'b1;
      OP_CLV: p_q[FLAG_V] = 1'b0;
      OP_CLD: p_q[FLAG_D] = 1'b0;
      OP_SED: p_q[FLAG_D] = 1'b1;
      OP_DEY: begin y_q = y_q - 8'd1; update_zn(y_q); end
      OP_INY: begin y_q = y_q + 8'd1; update_zn(y_q); end
      OP_DEX: begin x_q = x_q - 8'd1; update_zn(x_q); end
      OP_INX: begin x_q = x_q + 8'd1; update_zn(x_q); end
      OP_TYA: begin acc_q = y_q; update_zn(acc_q); end
      OP_TAY: begin y_q = acc_q; update_zn(y_q); end
      OP_TXA: begin acc_q = x_q; update_zn(acc_q); end
      OP_TAX: begin x_q = acc_q; update_zn(x_q); end
      OP_TXS: sp_q = x_q;
      OP_TSX: begin x_q = sp_q; update_zn(x_q); end
      OP_NOP: ;
      OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
        case (op[7:6])
          BR_SEL_N: flag_set = p_q[FLAG_N];
          BR_SEL_V: flag_set = p_q[FLAG_V];
          BR_SEL_C: flag_set = p_q[FLAG_C];
          default:  flag_set = p_q[FLAG_Z];
        endcase
        r.branch_taken = (flag_set == op[5]);
      end
      default: begin
        if (cc == CC_ALU) begin
          if (op == OP_STA_IMM) begin
            r.illegal = 1'b1;
          end else begin
            case (aaa)
              AAA_0: begin acc_q = acc_q | mv; update_zn(acc_q); end
              AAA_1: begin acc_q = acc_q & mv; update_zn(acc_q); end
              AAA_2: begin acc_q = acc_q ^ mv; update_zn(acc_q); end
              AAA_3: begin
                wide        = {1'b0, acc_q} + {1'b0, mv} + {8'd0, c_in};
                p_q[FLAG_C] = wide[8];
                p_q[FLAG_V] = (acc_q[7] == mv[7]) && (wide[7] != acc_q[7]);
                acc_q       = wide[7:0];
                update_zn(acc_q);
              end
              AAA_4: begin r.write_valid = 1'b1; r.write_data = acc_q; end
              AAA_5: begin acc_q = mv; update_zn(acc_q); end
              AAA_6: compare_regs(acc_q, mv);
              default: begin
                // binary subtract; bit 8 is the borrow out
                wide        = {1'b0, acc_q} - {1'b0, mv} - {8'd0, ~c_in};
                p_q[FLAG_C] = ~wide[8];
                p_q[FLAG_V] = (acc_q[7] != mv[7]) && (wide[7] != acc_q[7]);
                acc_q       = wide[7:0];
                update_zn(acc_q);
              end
            endcase
          end
        end else if (cc == CC_CTL) begin
          if (op == OP_BIT_ZP || op == OP_BIT_ABS) begin
            p_q[FLAG_Z] = ((mv & acc_q) == 8'h00);
            p_q[FLAG_V] = mv[6];
            p_q[FLAG_N] = mv[7];
          end else if (aaa == AAA_4 && STORE_MODES[bbb]) begin
            r.write_valid = 1'b1;
            r.write_data  = y_q;
          end else if (aaa == AAA_5 && LOAD_MODES[bbb]) begin
            y_q = mv;
            update_zn(y_q);
          end else if (aaa == AAA_6 && CMP_MODES[bbb]) begin
            compare_regs(y_q, mv);
          end else if (aaa == AAA_7 && CMP_MODES[bbb]) begin
            compare_regs(x_q, mv);
          end else begin
            r.illegal = 1'b1;
          end
        end else if (cc == CC_RMW) begin
          if (aaa <= AAA_3 && (bbb == BBB_ACC || RMW_MODES[bbb])) begin
            v = (bbb == BBB_ACC) ? acc_q : mv;
            case (aaa)
              AAA_0: begin c_new = v[7]; sh = {v[6:0], 1'b0}; end
              AAA_1: begin c_new = v[7]; sh = {v[6:0], c_in}; end
              AAA_2: begin c_new = v[0]; sh = {1'b0, v[7:1]}; end
              default: begin c_new = v[0]; sh = {c_in, v[7:1]}; end
            endcase
            p_q[FLAG_C] = c_new;
            update_zn(sh);
            if (bbb == BBB_ACC) begin
              acc_q = sh;
            end else begin
              r.write_valid = 1'b1;
              r.write_data  = sh;
            end
          end else if (aaa >= AAA_6 && RMW_MODES[bbb]) begin
            sh = (aaa == AAA_6) ? mv - 8'd1 : mv + 8'd1;
            update_zn(sh);
            r.write_valid = 1'b1;
            r.write_data  = sh;
          end else if (aaa == AAA_4 && STORE_MODES[bbb]) begin
            r.write_valid = 1'b1;
            r.write_data  = x_q;
          end else if (aaa == AAA_5 && LOAD_MODES[bbb]) begin
            x_q = mv;
            update_zn(x_q);
          end else begin
            r.illegal = 1'b1;
          end
        end else begin
          r.illegal = 1'b1;
        end
      end
    endcase
    r.acc_out   = acc_q;
    r.x_out     = x_q;
    r.y_out     = y_q;
    r.flags_out = p_q;
    return r;
  endfunction

  // Build a hand-written result for the directed table
  function automatic res_t outcome(input logic wv, input logic [7:0] wd,
                                   input stack_op_e sop, input logic [7:0] sidx,
                                   input logic br, input logic [7:0] a,
                                   input logic [7:0] x, input logic [7:0] y,
                                   input logic [7:0] p, input logic ill);
    res_t r;
    r.write_valid  = wv;
    r.write_data   = wd;
    r.stack_op     = sop;
    r.stack_index  = sidx;
    r.branch_taken = br;
    r.acc_out      = a;
    r.x_out        = x;
    r.y_out        = y;
    r.flags_out    = p;
    r.illegal      = ill;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] op, input logic [7:0] opnd,
                                  input logic typed, input res_t want);
    stim_row_t row;
    row.opcode  = op;
    row.operand = opnd;
    row.typed   = typed;
    row.want    = want;
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: idle at random, then hold the request until accepted.
  // Valid stays high from one request into the next when no gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] op, input logic [7:0] opnd,
                              input logic typed, input res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.operand_byte <= opnd;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // Advance the predicted state even when the row carries its own result
    predicted = execute_instr(op, opnd);
    if (typed) predicted = want;
    expected_results.push_back(predicted);
    requests_sent++;
    illegal_count += int'(predicted.illegal);
    store_count   += int'(predicted.write_valid);
    taken_count   += int'(predicted.branch_taken);
    if (predicted.stack_op != STACK_NONE) stack_count++;
  endtask

  // Half the opcodes walk all 256 values in order, the rest are random;
  // operands lean toward the byte extremes.
  task automatic send_random(input int count);
    logic [7:0] op;
    logic [7:0] opnd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        op           = opcode_sweep;
        opcode_sweep = opcode_sweep + 8'd1;
      end else begin
        op = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 7))
        0:       opnd = 8'h00;
        1:       opnd = 8'hFF;
        2:       opnd = 8'h80;
        3:       opnd = 8'h7F;
        default: opnd = 8'($urandom_range(0, 255));
      endcase
      send_request(op, opnd, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready, overridden by the long stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_if.ready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hold ready low long enough for the pipeline to fill and block requests
  initial begin : rx_long_stall
    wait (requests_sent >= STALL_AFTER);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic report_error(input string what, input res_t want, input res_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] result error: %s", $time, what);
      $display("  exp wv=%0d wd=%02h so=%0d si=%02h br=%0d a=%02h x=%02h y=%02h p=%02h ill=%0d",
               want.write_valid, want.write_data, want.stack_op, want.stack_index,
               want.branch_taken, want.acc_out, want.x_out, want.y_out,
               want.flags_out, want.illegal);
      $display("  got wv=%0d wd=%02h so=%0d si=%02h br=%0d a=%02h x=%02h y=%02h p=%02h ill=%0d",
               got.write_valid, got.write_data, got.stack_op, got.stack_index,
               got.branch_taken, got.acc_out, got.x_out, got.y_out,
               got.flags_out, got.illegal);
    end
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.write_valid  = out_if.write_valid;
      got.write_data   = out_if.write_data;
      got.stack_op     = stack_op_e'(out_if.stack_op);
      got.stack_index  = out_if.stack_index;
      got.branch_taken = out_if.branch_taken;
      got.acc_out      = out_if.acc_out;
      got.x_out        = out_if.x_out;
      got.y_out        = out_if.y_out;
      got.flags_out    = out_if.flags_out;
      got.illegal      = out_if.illegal;
      if (expected_results.size() == 0) begin
        report_error("result with no request outstanding", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) report_error("field differs", want, got);
      end
      results_checked++;
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("byte_cpu_execute_unit_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_NOP;
    in_if.operand_byte = 8'h00;
    out_if.ready       = 1'b0;

    acc_q = A_RESET;
    x_q   = 8'h00;
    y_q   = 8'h00;
    sp_q  = SP_RESET;
    p_q   = P_RESET;

    // Hand-written results hold from reset until the first JMP; the rest
    // come from the predictor.
    add_row(OP_JAM,     8'h00, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'h04, 1'b1));
    add_row(OP_BRK,     8'hFF, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'h04, 1'b1));
    add_row(OP_STA_IMM, 8'h5A, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'h04, 1'b1));
    add_row(OP_LDA_IMM, 8'h00, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'h06, 1'b0));
    add_row(OP_LDA_IMM, 8'hFF, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'hFF, 8'h00, 8'h00, 8'h84, 1'b0));
    // carry out of the top bit leaves zero
    add_row(OP_ADC_IMM, 8'h01, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'h07, 1'b0));
    // pushed flags carry bits 4 and 5 set
    add_row(OP_PHP,     8'h00, 1'b1, outcome(1'b1, 8'h37, STACK_PUSH, 8'hFD, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'h07, 1'b0));
    // pulled flags drop bits 4 and 5
    add_row(OP_PLP,     8'hFF, 1'b1, outcome(1'b0, 8'h00, STACK_PULL, 8'hFD, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'hCF, 1'b0));
    add_row(OP_JMP_ABS, 8'h00, 1'b1, outcome(1'b0, 8'h00, STACK_NONE, 8'h00, 1'b0,
                                             8'h00, 8'h00, 8'h00, 8'hCF, 1'b1));
    add_row(OP_BMI,     8'h00, 1'b0, '0);
    add_row(OP_BNE,     8'h00, 1'b0, '0);
    add_row(OP_SBC_IMM, 8'h80, 1'b0, '0);
    // stack pointer wrap: S=FF, pull to 00, push back to FF
    add_row(OP_LDX_IMM, 8'hFF, 1'b0, '0);
    add_row(OP_TXS,     8'h00, 1'b0, '0);
    add_row(OP_PLA,     8'h00, 1'b0, '0);
    add_row(OP_PHP,     8'h00, 1'b0, '0);
    add_row(OP_PHA,     8'h00, 1'b0, '0);
    add_row(OP_BIT_ZP,  8'hC0, 1'b0, '0);
    add_row(OP_ROR_ACC, 8'h00, 1'b0, '0);
    add_row(OP_ROL_ZP,  8'h81, 1'b0, '0);
    add_row(OP_INC_ZP,  8'hFF, 1'b0, '0);
    add_row(OP_DEC_ZP,  8'h00, 1'b0, '0);
    add_row(OP_CPY_IMM, 8'h7F, 1'b0, '0);
    add_row(OP_CPX_IMM, 8'h00, 1'b0, '0);
    add_row(OP_STX_ABS, 8'h00, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender mostly busy, receiver mostly idle
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].opcode, directed_rows[i].operand,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    send_random(RANDOM_PER_PHASE);

    // Drop valid and let every outstanding result drain before moving on
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);

    // Phase two: sender mostly idle, receiver mostly ready
    tx_idle_pct = 88;
    rx_idle_pct <= 10;
    send_random(RANDOM_PER_PHASE);

    // Phase three: back to back; the long output stall lands here
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    send_random(RANDOM_PER_PHASE);

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d instructions, %0d results checked: %0d illegal, %0d stores,",
             requests_sent, results_checked, illegal_count, store_count);
    $display("%0d stack accesses, %0d branches taken, three idle mixes and a %0d-cycle stall",
             stack_count, taken_count, STALL_CYCLES);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("byte_cpu_execute_unit_top: match");
    end else begin
      $display("byte_cpu_execute_unit_top: mismatch");
    end
    $finish;
  end

endmodule
